// ----- hw/rtl/sqg_pkg.sv -----
// Shared types, codes and arithmetic helpers for the single-qubit gate state vector unit.
package sqg_pkg;

  localparam int MAX_QUBITS_DEF = 10;

  localparam int AMP_W      = 32;
  localparam int COMP_W     = 16;
  localparam int INDEX_W    = 10;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int QREG_W     = 4;
  localparam int QN_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_APPLY = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_TARGET = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SATURATED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_QUBIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_00      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_01      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_10      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_11      = 3'd5;

  localparam logic [QREG_W-1:0] QUBIT_COUNT_RST  = 4'd10;
  localparam logic [QREG_W-1:0] TARGET_QUBIT_RST = 4'd0;
  localparam logic [AMP_W-1:0]  GATE_ONE_RST     = 32'd16384;
  localparam logic [AMP_W-1:0]  GATE_ZERO_RST    = 32'd0;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [INDEX_W-1:0]       amp_index;
    logic signed [COMP_W-1:0] in_re;
    logic signed [COMP_W-1:0] in_im;
  } req_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_re;
    logic signed [COMP_W-1:0] out_im;
    logic [STATUS_W-1:0]      status;
  } rsp_t;

  typedef struct packed {
    logic [AMP_W-1:0] g00;
    logic [AMP_W-1:0] g01;
    logic [AMP_W-1:0] g10;
    logic [AMP_W-1:0] g11;
  } gate_set_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp_i;
    logic [AMP_W-1:0] amp_j;
    logic             sat;
  } pair_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Q4.28 to Q2.14, round half up: floor((x + 2^13) / 2^14)
  function automatic logic signed [19:0] round_q14(input logic signed [32:0] x);
    logic signed [33:0] v;
    v = $signed({x[32], x}) + 34'sd8192;
    return v[33:14];
  endfunction

  function automatic logic sat_hit(input logic signed [20:0] v);
    return (v > 21'sd32767) || (v < -21'sd32768);
  endfunction

  function automatic logic signed [COMP_W-1:0] sat16(input logic signed [20:0] v);
    logic signed [COMP_W-1:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sqg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sqg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sqg_pair_alu.sv -----
// Three-stage butterfly datapath: complex multiply, round, sum and saturate for one pair.
module sqg_pair_alu #(
  parameter int TAG_W = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [TAG_W-1:0]        in_tag,
  input  logic [sqg_pkg::AMP_W-1:0] a_i,
  input  logic [sqg_pkg::AMP_W-1:0] a_j,
  input  sqg_pkg::gate_set_t      gate,
  output logic                    busy,
  output logic                    out_valid,
  output logic [TAG_W-1:0]        out_tag,
  output sqg_pkg::pair_result_t   result
);
  import sqg_pkg::*;

  // product slot c: 0 g00*a_i, 1 g01*a_j, 2 g11*a_j, 3 g10*a_i
  logic [AMP_W-1:0] gsel [4];
  logic [AMP_W-1:0] asel [4];

  logic signed [31:0] prod [4][4];
  logic signed [19:0] rnd [4][2];

  logic             v1, v2, v3;
  logic [TAG_W-1:0] tag1, tag2;

  always_comb begin
    gsel[0] = gate.g00;
    gsel[1] = gate.g01;
    gsel[2] = gate.g11;
    gsel[3] = gate.g10;
    asel[0] = a_i;
    asel[1] = a_j;
    asel[2] = a_j;
    asel[3] = a_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: sixteen 16x16 products
  always_ff @(posedge clk) begin
    tag1 <= in_tag;
    for (int c = 0; c < 4; c++) begin
      prod[c][0] <= 32'($signed(gsel[c][15:0]))  * 32'($signed(asel[c][15:0]));
      prod[c][1] <= 32'($signed(gsel[c][31:16])) * 32'($signed(asel[c][31:16]));
      prod[c][2] <= 32'($signed(gsel[c][15:0]))  * 32'($signed(asel[c][31:16]));
      prod[c][3] <= 32'($signed(gsel[c][31:16])) * 32'($signed(asel[c][15:0]));
    end
  end

  // stage 2: form each product component exactly, then round to Q2.14
  always_ff @(posedge clk) begin
    tag2 <= tag1;
    for (int c = 0; c < 4; c++) begin
      rnd[c][0] <= round_q14($signed({prod[c][0][31], prod[c][0]}) -
                             $signed({prod[c][1][31], prod[c][1]}));
      rnd[c][1] <= round_q14($signed({prod[c][2][31], prod[c][2]}) +
                             $signed({prod[c][3][31], prod[c][3]}));
    end
  end

  // stage 3: add the two rounded products and saturate
  logic signed [20:0] s_re_i, s_im_i, s_re_j, s_im_j;

  always_comb begin
    s_re_i = $signed({rnd[0][0][19], rnd[0][0]}) + $signed({rnd[1][0][19], rnd[1][0]});
    s_im_i = $signed({rnd[0][1][19], rnd[0][1]}) + $signed({rnd[1][1][19], rnd[1][1]});
    s_re_j = $signed({rnd[2][0][19], rnd[2][0]}) + $signed({rnd[3][0][19], rnd[3][0]});
    s_im_j = $signed({rnd[2][1][19], rnd[2][1]}) + $signed({rnd[3][1][19], rnd[3][1]});
  end

  always_ff @(posedge clk) begin
    out_tag      <= tag2;
    result.amp_i <= {sat16(s_im_i), sat16(s_re_i)};
    result.amp_j <= {sat16(s_im_j), sat16(s_re_j)};
    result.sat   <= sat_hit(s_re_i) | sat_hit(s_im_i) | sat_hit(s_re_j) | sat_hit(s_im_j);
  end

  assign busy      = v1 | v2;
  assign out_valid = v3;

endmodule

// ----- hw/rtl/single_qubit_gate_state_vector_unit.sv -----
// Top level: configuration, item sequencer, two-bank amplitude store and pair pipeline.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_ready  req  (action, amp_index, in_re, in_im)
//   result    out        rsp_valid/rsp_ready  rsp  (out_re, out_im, status)
//   config    in         cfg_we               cfg_index, cfg_data
//
// Write or bad item: to DONE; read: READ (registered RAM read), DONE; apply: RUN, DRAIN,
// DONE, one amplitude pair per cycle in RUN, set by the single read and write port of each
// bank (amplitudes split across two banks by index parity, so partners never collide).
// One item is in work at a time; a finished result waits in the output register while
// the next request is taken. Reset clears control state only; the store has no clear.
module single_qubit_gate_state_vector_unit #(
  parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  sqg_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output sqg_pkg::rsp_t                  rsp,
  input  logic                           cfg_we,
  input  logic [sqg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sqg_pkg::*;

  localparam int IDX_W = MAX_QUBITS;
  localparam int AW    = (IDX_W > 1) ? IDX_W - 1 : 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [AW:0] PAIR_ONE = 1;

  // configuration
  logic [QREG_W-1:0] qubit_count;
  logic [QREG_W-1:0] target_qubit;
  gate_set_t         gate;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count  <= QUBIT_COUNT_RST;
      target_qubit <= TARGET_QUBIT_RST;
      gate.g00     <= GATE_ONE_RST;
      gate.g01     <= GATE_ZERO_RST;
      gate.g10     <= GATE_ZERO_RST;
      gate.g11     <= GATE_ONE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUBIT_COUNT:  qubit_count  <= cfg_data[QREG_W-1:0];
        CFG_TARGET_QUBIT: target_qubit <= cfg_data[QREG_W-1:0];
        CFG_GATE_00:      gate.g00     <= cfg_data;
        CFG_GATE_01:      gate.g01     <= cfg_data;
        CFG_GATE_10:      gate.g10     <= cfg_data;
        CFG_GATE_11:      gate.g11     <= cfg_data;
        default: ;
      endcase
    end
  end

  // geometry derived from configuration
  logic [QN_W-1:0]  qc_ext, n_act, shift;
  logic             target_ok;
  logic [IDX_W-1:0] mask, low_mask;
  logic [AW:0]      pair_full;
  logic [AW-1:0]    pair_top;

  always_comb begin
    qc_ext = QN_W'(qubit_count);
    if (qc_ext == '0) begin
      n_act = QN_W'(1);
    end else if (qc_ext > QN_W'(MAX_QUBITS)) begin
      n_act = QN_W'(MAX_QUBITS);
    end else begin
      n_act = qc_ext;
    end
    target_ok = QN_W'(target_qubit) < n_act;
    shift     = n_act - QN_W'(1) - QN_W'(target_qubit);
    mask      = IDX_W'(1) << shift;
    low_mask  = mask - IDX_W'(1);
    pair_full = PAIR_ONE << (n_act - QN_W'(1));
    pair_top  = pair_full[AW-1:0] - AW'(1);
  end

  // request decode
  logic             req_acc;
  logic             in_range;
  logic [IDX_W-1:0] req_idx;
  logic             req_par;
  logic [AW-1:0]    req_addr;
  rsp_t             res_item;

  assign req_acc  = req_valid & req_ready;
  assign in_range = (req.amp_index >> n_act) == '0;
  assign req_idx  = IDX_W'(req.amp_index);
  assign req_par  = ^req_idx;
  assign req_addr = AW'(req_idx >> 1);

  always_comb begin
    res_item = '0;
    case (req.action)
      ACT_WRITE, ACT_READ: res_item.status = in_range ? STAT_OK : STAT_BAD_INDEX;
      ACT_APPLY:           res_item.status = target_ok ? STAT_OK : STAT_BAD_TARGET;
      default:             res_item.status = STAT_OK;
    endcase
  end

  // sequencer registers
  state_t           state, state_next;
  logic [AW-1:0]    pair_k;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_tag;
  logic             item_par;
  logic             sat_acc;
  rsp_t             res;
  logic             rsp_load;
  logic             drain_done;

  // pair addresses for the current issue slot
  logic [IDX_W-1:0] k_ext, pair_i, pair_j;
  logic             pi_par;

  always_comb begin
    k_ext  = IDX_W'(pair_k);
    pair_i = ((k_ext & ~low_mask) << 1) | (k_ext & low_mask);
    pair_j = pair_i | mask;
    pi_par = ^pair_i;
  end

  // memory banks
  logic             ram_we    [2];
  logic [AW-1:0]    ram_waddr [2];
  logic [AMP_W-1:0] ram_wdata [2];
  logic [AW-1:0]    ram_raddr [2];
  logic [AMP_W-1:0] ram_rdata [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    sqg_ram #(
      .WIDTH(AMP_W),
      .DEPTH(DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (ram_we[b]),
      .waddr(ram_waddr[b]),
      .wdata(ram_wdata[b]),
      .raddr(ram_raddr[b]),
      .rdata(ram_rdata[b])
    );
  end

  // pair pipeline
  logic             rd_par;
  logic [AMP_W-1:0] a_i, a_j;
  logic             alu_busy, alu_valid;
  logic [IDX_W-1:0] alu_tag, wb_j;
  logic             wb_par;
  pair_result_t     alu_res;

  assign rd_par = ^rd_tag;
  assign a_i    = rd_par ? ram_rdata[1] : ram_rdata[0];
  assign a_j    = rd_par ? ram_rdata[0] : ram_rdata[1];

  sqg_pair_alu #(
    .TAG_W(IDX_W)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_tag   (rd_tag),
    .a_i      (a_i),
    .a_j      (a_j),
    .gate     (gate),
    .busy     (alu_busy),
    .out_valid(alu_valid),
    .out_tag  (alu_tag),
    .result   (alu_res)
  );

  assign wb_par     = ^alu_tag;
  assign wb_j       = alu_tag | mask;
  assign drain_done = !rd_valid && !alu_busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          case (req.action)
            ACT_READ:  state_next = in_range ? ST_READ : ST_DONE;
            ACT_APPLY: state_next = target_ok ? ST_RUN : ST_DONE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_RUN:   if (pair_k == pair_top) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_next = ST_DONE;
      ST_DONE:  if (rsp_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    req_ready = 1'b0;
    rsp_load  = 1'b0;
    for (int b = 0; b < 2; b++) begin
      ram_we[b]    = 1'b0;
      ram_waddr[b] = req_addr;
      ram_wdata[b] = {req.in_im, req.in_re};
      ram_raddr[b] = req_addr;
    end
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_acc && req.action == ACT_WRITE && in_range) begin
          ram_we[0] = !req_par;
          ram_we[1] = req_par;
        end
      end
      ST_RUN: begin
        ram_raddr[0] = pi_par ? AW'(pair_j >> 1) : AW'(pair_i >> 1);
        ram_raddr[1] = pi_par ? AW'(pair_i >> 1) : AW'(pair_j >> 1);
      end
      ST_DONE: rsp_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
    // write back finished pairs; only happens in RUN or DRAIN
    if (alu_valid) begin
      ram_we[0]    = 1'b1;
      ram_we[1]    = 1'b1;
      ram_waddr[0] = wb_par ? AW'(wb_j >> 1) : AW'(alu_tag >> 1);
      ram_waddr[1] = wb_par ? AW'(alu_tag >> 1) : AW'(wb_j >> 1);
      ram_wdata[0] = wb_par ? alu_res.amp_j : alu_res.amp_i;
      ram_wdata[1] = wb_par ? alu_res.amp_i : alu_res.amp_j;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_RUN);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= pair_i;
    if (rsp_load) begin
      rsp <= res;
    end
    if (state == ST_RUN) begin
      pair_k <= pair_k + AW'(1);
    end
    if (alu_valid && alu_res.sat) begin
      sat_acc <= 1'b1;
    end
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          res      <= res_item;
          item_par <= req_par;
          pair_k   <= '0;
          sat_acc  <= 1'b0;
        end
      end
      ST_READ: begin
        res.out_re <= item_par ? ram_rdata[1][15:0]  : ram_rdata[0][15:0];
        res.out_im <= item_par ? ram_rdata[1][31:16] : ram_rdata[0][31:16];
        res.status <= STAT_OK;
      end
      ST_DRAIN: begin
        // include the pair being written back this cycle
        if (drain_done) begin
          res.status <= (sat_acc || (alu_valid && alu_res.sat)) ? STAT_SATURATED : STAT_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/sqg_checker.sv -----
// Port-level checker for the single-qubit gate state vector unit, bound to the top level.
module sqg_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sqg_pkg::rsp_t rsp
);
  import sqg_pkg::*;

  // requests taken whose result has not been taken yet
  logic [1:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without a request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests in flight");

  a_fields_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.out_re != 16'sd0 || rsp.out_im != 16'sd0) |-> rsp.status == STAT_OK)
    else $error("amplitude returned with an error status");

endmodule

bind single_qubit_gate_state_vector_unit sqg_checker u_checker (.*);
